// ----- src/cbm_pkg.sv -----
// shared constants and helpers for the cartridge bank mapper
package cbm_pkg;

  // sizes
  localparam int MAX_BANKS  = 256;
  localparam int SRAM_BYTES = 32768;
  localparam int SRAM_AW    = $clog2(SRAM_BYTES);
  localparam int BANK_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int OFFSET_W   = 22;
  localparam int SLOT_AW    = 14;

  localparam logic [COUNT_W-1:0] MAX_BANKS_W   = COUNT_W'(MAX_BANKS);
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 9'd32;
  localparam logic [SRAM_AW-1:0] SRAM_LAST     = SRAM_AW'(SRAM_BYTES - 1);
  localparam logic [SRAM_AW:0]   SRAM_BYTES_W  = (SRAM_AW + 1)'(SRAM_BYTES);

  // address map
  localparam logic [ADDR_W-1:0] ADDR_VECTOR_END = 16'h03FF;
  localparam logic [ADDR_W-1:0] ADDR_SLOT2_BASE = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT2_END  = 16'hBFFF;
  localparam logic [ADDR_W-1:0] ADDR_SRAM_CTRL  = 16'hFFFC;
  localparam logic [ADDR_W-1:0] ADDR_BANK0      = 16'hFFFD;

  // control byte bits at FFFC
  localparam int CTRL_BANK_BIT = 2;
  localparam int CTRL_MAP_BIT  = 3;

  // access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // result sources
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_ROM  = 2'd1;
  localparam logic [1:0] SRC_SRAM = 2'd2;

  // save ram index from the offset within slot 2 and the bank bit
  function automatic logic [SRAM_AW-1:0] sram_index(input logic [SLOT_AW-1:0] inner,
                                                    input logic bank_bit);
    logic [SRAM_AW:0] raw;
    raw = (SRAM_AW + 1)'({bank_bit, inner});
    if (raw >= SRAM_BYTES_W) begin
      raw = raw - SRAM_BYTES_W;
    end
    return raw[SRAM_AW-1:0];
  endfunction

endpackage

// ----- src/cartridge_bank_mapper_with_sram_unit.sv -----
// top level of the cartridge bank mapper with save ram
// Usage:
//   An access word (command_i, bus_address_i, write_byte_i) is taken at a
//   rising edge with start high and busy low. Exactly one result word per
//   access appears on source_o, rom_offset_o and read_data_o for one cycle
//   with done_o high; the receiver cannot stall, so it must take it then.
//   Reads and ordinary writes pass through S_EXEC and S_RESP before done_o
//   rises; a bank select write (FFFD-FFFF) also waits in S_MOD for the
//   8-step remainder unit that reduces the byte by the bank count. busy
//   drops in the cycle done_o is shown, so the next access may be taken
//   at that edge. The bank count register (cfg_we_i, cfg_wdata_i) must be
//   written only while the block is idle; the block does not enforce it.
//   Counts above 256 act as 256.
//   After reset the save ram is cleared one byte a cycle: busy stays high
//   until all of it is cleared, and no access is taken before. Slot banks
//   reset to 0, 1, 2, the ram controls to zero and the bank count to 32.
module cartridge_bank_mapper_with_sram_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [cbm_pkg::ADDR_W-1:0]    bus_address_i,
  input  logic [cbm_pkg::DATA_W-1:0]    write_byte_i,
  input  logic                          cfg_we_i,
  input  logic [cbm_pkg::COUNT_W-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [1:0]                    source_o,
  output logic [cbm_pkg::OFFSET_W-1:0]  rom_offset_o,
  output logic [cbm_pkg::DATA_W-1:0]    read_data_o
);
  import cbm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_MOD   = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [SRAM_AW-1:0]   clr_q;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_eff;
  logic                 cmd_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [DATA_W-1:0]    wbyte_q;
  logic [BANK_W-1:0]    slot_bank_q [3];
  logic                 sram_bit_q;
  logic                 sram_map_q;
  logic [DATA_W-1:0]    sram_mem [SRAM_BYTES];
  logic [DATA_W-1:0]    rdata_q;
  logic                 done_q;
  logic [1:0]           source_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic [DATA_W-1:0]    rd_q;

  logic                 accept;
  logic                 in_slot2;
  logic                 is_bank_wr;
  logic [1:0]           bank_sel;
  logic [SRAM_AW-1:0]   acc_idx;
  logic                 mem_we;
  logic [SRAM_AW-1:0]   mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;
  logic                 mod_start;
  logic                 mod_done;
  logic [DATA_W-1:0]    mod_rem;
  logic [1:0]           slot;
  logic [BANK_W-1:0]    cur_bank;
  logic [1:0]           source_d;
  logic [OFFSET_W-1:0]  offset_d;
  logic [DATA_W-1:0]    rd_d;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign count_eff = (count_q > MAX_BANKS_W) ? MAX_BANKS_W : count_q;

  // decode of the held access
  assign in_slot2   = (addr_q >= ADDR_SLOT2_BASE) && (addr_q <= ADDR_SLOT2_END);
  assign is_bank_wr = (addr_q >= ADDR_BANK0);
  assign bank_sel   = addr_q[1:0] - 2'd1;
  assign acc_idx    = sram_index(addr_q[SLOT_AW-1:0], sram_bit_q);
  assign slot       = addr_q[ADDR_W-1:SLOT_AW];
  assign cur_bank   = (slot == 2'd3) ? '0 : slot_bank_q[slot];

  // remainder unit for bank selects
  assign mod_start = (state_q == S_EXEC) && (cmd_q == CMD_WRITE) && is_bank_wr;

  cbm_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (wbyte_q),
    .divisor_i  (count_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SRAM_LAST) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = mod_start ? S_MOD : S_RESP;
      S_MOD:   if (mod_done) state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // bank count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // access word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      addr_q  <= bus_address_i;
      wbyte_q <= write_byte_i;
    end
  end

  // mapper registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bank_q[0] <= 8'd0;
      slot_bank_q[1] <= 8'd1;
      slot_bank_q[2] <= 8'd2;
      sram_bit_q     <= 1'b0;
      sram_map_q     <= 1'b0;
    end else begin
      if ((state_q == S_EXEC) && (cmd_q == CMD_WRITE) && (addr_q == ADDR_SRAM_CTRL)) begin
        sram_bit_q <= wbyte_q[CTRL_BANK_BIT];
        sram_map_q <= wbyte_q[CTRL_MAP_BIT];
      end
      if ((state_q == S_MOD) && mod_done) begin
        slot_bank_q[bank_sel] <= (count_eff == '0) ? '0 : mod_rem;
      end
    end
  end

  // save ram write port: clearing pass or slot 2 store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_idx;
    mem_wdata = wbyte_q;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if ((state_q == S_EXEC) && (cmd_q == CMD_WRITE) && in_slot2 && sram_map_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sram_mem[mem_waddr] <= mem_wdata;
    end
  end

  // save ram read port
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      rdata_q <= sram_mem[acc_idx];
    end
  end

  // result word
  always_comb begin
    source_d = SRC_NONE;
    offset_d = '0;
    rd_d     = '0;
    if (cmd_q == CMD_READ) begin
      if (addr_q <= ADDR_VECTOR_END) begin
        source_d = SRC_ROM;
        offset_d = OFFSET_W'(addr_q);
      end else if (addr_q <= ADDR_SLOT2_END) begin
        if ((slot == 2'd2) && sram_map_q) begin
          source_d = SRC_SRAM;
          rd_d     = rdata_q;
        end else if (COUNT_W'(cur_bank) < count_eff) begin
          source_d = SRC_ROM;
          offset_d = {cur_bank, addr_q[SLOT_AW-1:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP) begin
      source_q <= source_d;
      offset_q <= offset_d;
      rd_q     <= rd_d;
    end
  end

  assign done_o       = done_q;
  assign source_o     = source_q;
  assign rom_offset_o = offset_q;
  assign read_data_o  = rd_q;

endmodule

// ----- src/cbm_mod.sv -----
// iterative remainder unit, one quotient bit per cycle
module cbm_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cbm_pkg::DATA_W-1:0]   dividend_i,
  input  logic [cbm_pkg::COUNT_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [cbm_pkg::DATA_W-1:0]   rem_o
);
  import cbm_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  logic                run_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [COUNT_W-1:0]  rem_q;
  logic [DATA_W-1:0]   dvd_q;
  logic [COUNT_W-1:0]  trial;
  logic [COUNT_W-1:0]  rem_d;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q[DATA_W-1:0], dvd_q[DATA_W-1]};
    rem_d = (trial >= divisor_i) ? (trial - divisor_i) : trial;
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DATA_W-1:0];

endmodule

// ----- src/cbm_checker.sv -----
// port-level checker for the bank mapper and its bind
module cbm_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [1:0]                    source_o,
  input logic [cbm_pkg::OFFSET_W-1:0]  rom_offset_o,
  input logic [cbm_pkg::DATA_W-1:0]    read_data_o
);
  import cbm_pkg::*;

  // an accepted word makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result word only ends a busy stretch
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without pending access");

  // source code is one of the three meanings
  a_source_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (source_o == SRC_NONE || source_o == SRC_ROM || source_o == SRC_SRAM))
    else $error("illegal source code");

  // payloads not selected by source read as zero
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && source_o != SRC_ROM) |-> (rom_offset_o == '0))
    else $error("rom offset set without rom source");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && source_o != SRC_SRAM) |-> (read_data_o == '0))
    else $error("read data set without sram source");

endmodule

bind cartridge_bank_mapper_with_sram_unit cbm_port_checker u_cbm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .source_o     (source_o),
  .rom_offset_o (rom_offset_o),
  .read_data_o  (read_data_o)
);
